[rtl/llr_pkg.sv]
// ----------------------------------------------------------------------------
// llr_pkg: shared types and constants of the left/right ambiguity resolver
// Fixed-point widths, combination codes and the result record.
// ----------------------------------------------------------------------------
package llr_pkg;

    localparam int POS_W           = 32;
    localparam int INC_W           = 24;
    localparam int FLOOR_W         = 21;
    localparam int SLOPE_FRAC_BITS = 20;
    localparam int PROB_BITS       = 16;
    localparam int PROB_W          = PROB_BITS + 1;

    // Magnitude of a coordinate difference.
    localparam int MAG_W  = POS_W + 1;
    // Slope quotient bits kept; anything at or above 2^QUO_W saturates anyway.
    localparam int QUO_W  = 40;
    // Saturated estimator width.
    localparam int EST_W  = 38;
    localparam int SUM_W  = EST_W + 1;
    // Rounded probability numerator: n * 2^PROB_BITS + s / 2.
    localparam int RNUM_W = EST_W + PROB_BITS + 1;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 21'd44939;

    typedef enum logic [1:0] {
        COMBO_HH = 2'd0,
        COMBO_HM = 2'd1,
        COMBO_MH = 2'd2,
        COMBO_MM = 2'd3
    } combo_t;

    typedef struct packed {
        logic               updated;
        logic               gap_error;
        combo_t             best_combo;
        logic [PROB_W-1:0]  prob_hit0;
        logic [PROB_W-1:0]  prob_hit1;
        logic               hit0_first_mirror;
        logic               hit1_first_mirror;
        logic               mirror0_first_mirror;
        logic               mirror1_first_mirror;
    } res_t;

endpackage

[rtl/llr_slope_div.sv]
// ----------------------------------------------------------------------------
// llr_slope_div: pipelined slope divider
// Computes floor(mag * 2^SLOPE_FRAC_BITS / den), one quotient bit per stage,
// and flags quotients that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module llr_slope_div
    import llr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag,
    input  logic [MAG_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int HI_W = MAG_W - SLOPE_FRAC_BITS;

    logic [MAG_W-1:0] rem_reg [0:QUO_W];
    logic [QUO_W-1:0] low_reg [0:QUO_W];
    logic [MAG_W-1:0] den_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic [MAG_W-1:0] hi_part;

    // The numerator bits above the quotient range form the first partial
    // remainder; if they already reach the divisor, the quotient overflows.
    assign hi_part = {{SLOPE_FRAC_BITS{1'b0}}, mag[MAG_W-1:MAG_W-HI_W]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi_part;
            low_reg[0] <= {mag[SLOPE_FRAC_BITS-1:0], {(QUO_W-SLOPE_FRAC_BITS){1'b0}}};
            den_reg[0] <= den;
            ovf_reg[0] <= (hi_part >= den);
        end
    end

    // The low word shifts numerator bits out at the top and quotient bits in
    // at the bottom, so it holds the quotient after the last stage.
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[i], low_reg[i][QUO_W-1]};
            diff  = trial - {1'b0, den_reg[i]};
            ge    = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                low_reg[i+1] <= {low_reg[i][QUO_W-2:0], ge};
                den_reg[i+1] <= den_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign quo = low_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

[rtl/llr_prob_div.sv]
// ----------------------------------------------------------------------------
// llr_prob_div: pipelined probability divider
// Computes floor(num / den) for num < den * 2^PROB_W, one bit per stage.
// ----------------------------------------------------------------------------
module llr_prob_div
    import llr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RNUM_W-1:0] num,
    input  logic [SUM_W-1:0]  den,
    output logic [PROB_W-1:0] quo
);

    logic [SUM_W-1:0]  rem_reg [0:PROB_W];
    logic [PROB_W-1:0] low_reg [0:PROB_W];
    logic [SUM_W-1:0]  den_reg [0:PROB_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {{(SUM_W-(RNUM_W-PROB_W)){1'b0}}, num[RNUM_W-1:PROB_W]};
            low_reg[0] <= num[PROB_W-1:0];
            den_reg[0] <= den;
        end
    end

    for (genvar i = 0; i < PROB_W; i++)
    begin : g_step
        logic [SUM_W:0] trial;
        logic [SUM_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[i], low_reg[i][PROB_W-1]};
            diff  = trial - {1'b0, den_reg[i]};
            ge    = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                low_reg[i+1] <= {low_reg[i][PROB_W-2:0], ge};
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quo = low_reg[PROB_W];

endmodule

[rtl/left_right_ambiguity_resolver.sv]
// ----------------------------------------------------------------------------
// left_right_ambiguity_resolver: drift hit pair left/right resolution
// Throughput: one hit pair per cycle unless in_stall is raised (skid entry
// occupied); the 40-stage slope dividers and the 17-stage probability
// dividers retire one quotient bit per stage.
// Reset: rst_n clears all valid bits and restores estimator_floor to 44939.
// ----------------------------------------------------------------------------
module left_right_ambiguity_resolver
    import llr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [POS_W-1:0]  pos_hit0,
    input  logic signed [POS_W-1:0]  plane_hit0,
    input  logic signed [POS_W-1:0]  pos_hit1,
    input  logic signed [POS_W-1:0]  plane_hit1,
    input  logic                     has_mirror0,
    input  logic signed [POS_W-1:0]  pos_mirror0,
    input  logic                     has_mirror1,
    input  logic signed [POS_W-1:0]  pos_mirror1,
    input  logic signed [INC_W-1:0]  incidence,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     updated,
    output logic                     gap_error,
    output logic [1:0]               best_combo,
    output logic [PROB_W-1:0]        prob_hit0,
    output logic [PROB_W-1:0]        prob_hit1,
    output logic                     hit0_first_mirror,
    output logic                     hit1_first_mirror,
    output logic                     mirror0_first_mirror,
    output logic                     mirror1_first_mirror,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [FLOOR_W-1:0]       estimator_floor
);

    localparam int SDL  = QUO_W + 1;
    localparam int PDL  = PROB_W + 1;
    localparam int XT_W = QUO_W + 2;
    localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1) << PROB_BITS;
    localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(1) << (PROB_BITS - 1);

    typedef struct packed {
        logic hm0;
        logic hm1;
        logic gap;
    } ctl_t;

    typedef struct packed {
        logic [3:0]       neg;
        logic [INC_W-1:0] inc;
    } sgn_t;

    typedef struct packed {
        logic e1_e0;
        logic e2_e0;
        logic e2_e1;
        logic e3_e0;
        logic e3_e1;
        logic e3_e2;
    } raw_lt_t;

    typedef struct packed {
        logic d3_d2;
        logic d3_d1;
        logic d2_d3;
        logic d2_d0;
        logic d1_d0;
        logic d1_d3;
        logic d0_d1;
        logic d0_d2;
    } cmp_t;

    typedef struct packed {
        combo_t flag;
        logic   f0;
        logic   f1;
        logic   fm0;
        logic   fm1;
    } fl_t;

    typedef struct packed {
        fl_t  fl;
        logic sz0;
        logic sz1;
    } sel_t;

    logic                en;
    logic [FLOOR_W-1:0]  floor_reg;
    logic [EST_W-1:0]    floor_ext;

    // Stage 1: differences.
    logic                v1_reg;
    logic [MAG_W-1:0]    diff1_reg [4];
    logic [MAG_W-1:0]    dz1_reg;
    logic                hm0_1_reg;
    logic                hm1_1_reg;
    logic [INC_W-1:0]    inc1_reg;

    // Stage 2: magnitudes and quotient signs.
    logic                v2_reg;
    logic [MAG_W-1:0]    mag2_reg [4];
    logic [MAG_W-1:0]    den2_reg;
    ctl_t                ctl2_reg;
    sgn_t                sgn2_reg;

    logic [QUO_W-1:0]    quo_w [4];
    logic                ovf_w [4];
    logic                vd_reg   [SDL];
    ctl_t                ctld_reg [SDL];
    sgn_t                sgnd_reg [SDL];

    // Stages 3 to 5: signed slope, mismatch, saturated magnitude.
    logic                v3_reg;
    logic [QUO_W:0]      qs3_reg [4];
    logic [3:0]          ovf3_reg;
    ctl_t                ctl3_reg;
    logic [INC_W-1:0]    inc3_reg;

    logic                v4_reg;
    logic [XT_W-1:0]     t4_reg [4];
    logic [3:0]          ovf4_reg;
    ctl_t                ctl4_reg;

    logic                v5_reg;
    logic [EST_W-1:0]    e5_reg [4];
    ctl_t                ctl5_reg;

    // Stages 6 to 8: best combination and floored estimators.
    logic                v6_reg;
    raw_lt_t             lt6_reg;
    logic [EST_W-1:0]    fl6_reg [4];
    ctl_t                ctl6_reg;

    logic                v7_reg;
    combo_t              flag7_reg;
    logic [EST_W-1:0]    d7_reg [4];
    ctl_t                ctl7_reg;
    combo_t              flag7_next;
    logic [EST_W-1:0]    d7_next [4];

    logic                v8_reg;
    combo_t              flag8_reg;
    cmp_t                cmp8_reg;
    logic [EST_W-1:0]    d8_reg [4];
    ctl_t                ctl8_reg;

    // Stages 9 to 11: probability operands.
    logic                v9_reg;
    logic [EST_W-1:0]    n9_reg [2];
    logic [EST_W-1:0]    o9_reg [2];
    fl_t                 fl9_reg;
    ctl_t                ctl9_reg;
    logic [EST_W-1:0]    n9_next [2];
    logic [EST_W-1:0]    o9_next [2];
    fl_t                 fl9_next;

    logic                v10_reg;
    logic [EST_W-1:0]    n10_reg [2];
    logic [SUM_W-1:0]    s10_reg [2];
    fl_t                 fl10_reg;
    ctl_t                ctl10_reg;

    logic                v11_reg;
    logic [RNUM_W-1:0]   num11_reg [2];
    logic [SUM_W-1:0]    den11_reg [2];
    sel_t                sel11_reg;
    ctl_t                ctl11_reg;

    logic [PROB_W-1:0]   pq_w [2];
    logic                vp_reg   [PDL];
    sel_t                selp_reg [PDL];
    ctl_t                ctlp_reg [PDL];

    // Output register with one skid entry.
    res_t                res_w;
    logic                v_last;
    logic                take_out;
    logic                load_skid;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    res_t                out_reg;
    res_t                skid_reg;

    // The pipeline freezes only while the skid entry is occupied.
    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign floor_ext = {{(EST_W-FLOOR_W){1'b0}}, floor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            floor_reg <= estimator_floor;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            for (int i = 0; i < SDL; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
            for (int i = 0; i < PDL; i++)
            begin
                vp_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < SDL; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            v3_reg    <= vd_reg[SDL-1];
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            v8_reg    <= v7_reg;
            v9_reg    <= v8_reg;
            v10_reg   <= v9_reg;
            v11_reg   <= v10_reg;
            vp_reg[0] <= v11_reg;
            for (int i = 1; i < PDL; i++)
            begin
                vp_reg[i] <= vp_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff1_reg[0] <= {pos_hit0[POS_W-1], pos_hit0} - {pos_hit1[POS_W-1], pos_hit1};
            diff1_reg[1] <= {pos_hit0[POS_W-1], pos_hit0} - {pos_mirror1[POS_W-1], pos_mirror1};
            diff1_reg[2] <= {pos_mirror0[POS_W-1], pos_mirror0} - {pos_hit1[POS_W-1], pos_hit1};
            diff1_reg[3] <= {pos_mirror0[POS_W-1], pos_mirror0}
                            - {pos_mirror1[POS_W-1], pos_mirror1};
            dz1_reg      <= {plane_hit0[POS_W-1], plane_hit0} - {plane_hit1[POS_W-1], plane_hit1};
            hm0_1_reg    <= has_mirror0;
            hm1_1_reg    <= has_mirror1;
            inc1_reg     <= incidence;

            for (int k = 0; k < 4; k++)
            begin
                mag2_reg[k]     <= diff1_reg[k][MAG_W-1] ? (MAG_W'(0) - diff1_reg[k])
                                                         : diff1_reg[k];
                sgn2_reg.neg[k] <= diff1_reg[k][MAG_W-1] ^ dz1_reg[MAG_W-1];
            end
            den2_reg     <= dz1_reg[MAG_W-1] ? (MAG_W'(0) - dz1_reg) : dz1_reg;
            sgn2_reg.inc <= inc1_reg;
            ctl2_reg.hm0 <= hm0_1_reg;
            ctl2_reg.hm1 <= hm1_1_reg;
            ctl2_reg.gap <= (dz1_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Slope dividers, with control carried alongside
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 4; k++)
    begin : g_slope
        llr_slope_div u_div (
            .clk (clk),
            .en  (en),
            .mag (mag2_reg[k]),
            .den (den2_reg),
            .quo (quo_w[k]),
            .ovf (ovf_w[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctld_reg[0] <= ctl2_reg;
            sgnd_reg[0] <= sgn2_reg;
            for (int i = 1; i < SDL; i++)
            begin
                ctld_reg[i] <= ctld_reg[i-1];
                sgnd_reg[i] <= sgnd_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 6: mismatch estimators
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                qs3_reg[k]  <= sgnd_reg[SDL-1].neg[k] ? ((QUO_W+1)'(0) - {1'b0, quo_w[k]})
                                                      : {1'b0, quo_w[k]};
                ovf3_reg[k] <= ovf_w[k];
                t4_reg[k]   <= {qs3_reg[k][QUO_W], qs3_reg[k]}
                               - {{(XT_W-INC_W){inc3_reg[INC_W-1]}}, inc3_reg};
            end
            ctl3_reg <= ctld_reg[SDL-1];
            inc3_reg <= sgnd_reg[SDL-1].inc;
            ovf4_reg <= ovf3_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_est
        logic [XT_W-1:0] abs_t;
        logic            sat;

        always_comb
        begin
            abs_t = t4_reg[k][XT_W-1] ? (XT_W'(0) - t4_reg[k]) : t4_reg[k];
            sat   = ovf4_reg[k] || (|abs_t[XT_W-1:EST_W]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e5_reg[k]  <= sat ? {EST_W{1'b1}} : abs_t[EST_W-1:0];
                fl6_reg[k] <= (e5_reg[k] < floor_ext) ? floor_ext : e5_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl5_reg      <= ctl4_reg;
            lt6_reg.e1_e0 <= (e5_reg[1] < e5_reg[0]);
            lt6_reg.e2_e0 <= (e5_reg[2] < e5_reg[0]);
            lt6_reg.e2_e1 <= (e5_reg[2] < e5_reg[1]);
            lt6_reg.e3_e0 <= (e5_reg[3] < e5_reg[0]);
            lt6_reg.e3_e1 <= (e5_reg[3] < e5_reg[1]);
            lt6_reg.e3_e2 <= (e5_reg[3] < e5_reg[2]);
            ctl6_reg      <= ctl5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: best combination from the raw estimators, first one wins ties;
    // combinations with an absent mirror take over the hit's estimator.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic   take1;
        logic   take2;
        logic   take3;
        combo_t cand;
        logic   lt3;

        take1 = ctl6_reg.hm1 && lt6_reg.e1_e0;
        take2 = ctl6_reg.hm0 && (take1 ? lt6_reg.e2_e1 : lt6_reg.e2_e0);
        cand  = take2 ? COMBO_MH : (take1 ? COMBO_HM : COMBO_HH);
        unique case (cand)
            COMBO_MH: lt3 = lt6_reg.e3_e2;
            COMBO_HM: lt3 = lt6_reg.e3_e1;
            default:  lt3 = lt6_reg.e3_e0;
        endcase
        take3      = ctl6_reg.hm0 && ctl6_reg.hm1 && lt3;
        flag7_next = take3 ? COMBO_MM : cand;

        d7_next[0] = fl6_reg[0];
        d7_next[1] = ctl6_reg.hm1 ? fl6_reg[1] : fl6_reg[0];
        d7_next[2] = ctl6_reg.hm0 ? fl6_reg[2] : fl6_reg[0];
        if (ctl6_reg.hm0 && ctl6_reg.hm1)
        begin
            d7_next[3] = fl6_reg[3];
        end
        else
        begin
            d7_next[3] = ctl6_reg.hm1 ? d7_next[1] : d7_next[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag7_reg      <= flag7_next;
            d7_reg         <= d7_next;
            ctl7_reg       <= ctl6_reg;

            flag8_reg      <= flag7_reg;
            d8_reg         <= d7_reg;
            ctl8_reg       <= ctl7_reg;
            cmp8_reg.d3_d2 <= (d7_reg[3] < d7_reg[2]);
            cmp8_reg.d3_d1 <= (d7_reg[3] < d7_reg[1]);
            cmp8_reg.d2_d3 <= (d7_reg[2] < d7_reg[3]);
            cmp8_reg.d2_d0 <= (d7_reg[2] < d7_reg[0]);
            cmp8_reg.d1_d0 <= (d7_reg[1] < d7_reg[0]);
            cmp8_reg.d1_d3 <= (d7_reg[1] < d7_reg[3]);
            cmp8_reg.d0_d1 <= (d7_reg[0] < d7_reg[1]);
            cmp8_reg.d0_d2 <= (d7_reg[0] < d7_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: pick each probability as n / (n + o) against the runner-up.
    // ------------------------------------------------------------------
    always_comb
    begin
        fl9_next.flag = flag8_reg;
        unique case (flag8_reg)
            COMBO_HH:
            begin
                n9_next[0]   = cmp8_reg.d3_d2 ? d8_reg[3] : d8_reg[2];
                o9_next[0]   = d8_reg[0];
                n9_next[1]   = cmp8_reg.d3_d1 ? d8_reg[3] : d8_reg[1];
                o9_next[1]   = d8_reg[0];
                fl9_next.f0  = 1'b0;
                fl9_next.f1  = 1'b0;
                fl9_next.fm0 = cmp8_reg.d3_d2;
                fl9_next.fm1 = cmp8_reg.d3_d1;
            end
            COMBO_HM:
            begin
                n9_next[0]   = cmp8_reg.d2_d3 ? d8_reg[2] : d8_reg[3];
                o9_next[0]   = d8_reg[1];
                n9_next[1]   = d8_reg[1];
                o9_next[1]   = cmp8_reg.d2_d0 ? d8_reg[2] : d8_reg[0];
                fl9_next.f0  = 1'b1;
                fl9_next.f1  = cmp8_reg.d2_d0;
                fl9_next.fm0 = !cmp8_reg.d2_d3;
                fl9_next.fm1 = 1'b0;
            end
            COMBO_MH:
            begin
                n9_next[0]   = d8_reg[2];
                o9_next[0]   = cmp8_reg.d1_d0 ? d8_reg[1] : d8_reg[0];
                n9_next[1]   = cmp8_reg.d1_d3 ? d8_reg[1] : d8_reg[3];
                o9_next[1]   = d8_reg[2];
                fl9_next.f0  = cmp8_reg.d1_d0;
                fl9_next.f1  = 1'b1;
                fl9_next.fm0 = 1'b0;
                fl9_next.fm1 = !cmp8_reg.d1_d3;
            end
            COMBO_MM:
            begin
                n9_next[0]   = d8_reg[3];
                o9_next[0]   = cmp8_reg.d0_d1 ? d8_reg[0] : d8_reg[1];
                n9_next[1]   = d8_reg[3];
                o9_next[1]   = cmp8_reg.d0_d2 ? d8_reg[0] : d8_reg[2];
                fl9_next.f0  = !cmp8_reg.d0_d1;
                fl9_next.f1  = !cmp8_reg.d0_d2;
                fl9_next.fm0 = 1'b1;
                fl9_next.fm1 = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n9_reg    <= n9_next;
            o9_reg    <= o9_next;
            fl9_reg   <= fl9_next;
            ctl9_reg  <= ctl8_reg;

            for (int j = 0; j < 2; j++)
            begin
                n10_reg[j]   <= n9_reg[j];
                s10_reg[j]   <= {1'b0, n9_reg[j]} + {1'b0, o9_reg[j]};
                // Round to nearest: n * 2^PROB_BITS + floor(s / 2).
                num11_reg[j] <= RNUM_W'({n10_reg[j], {PROB_BITS{1'b0}}})
                                + RNUM_W'(s10_reg[j][SUM_W-1:1]);
                den11_reg[j] <= s10_reg[j];
            end
            fl10_reg      <= fl9_reg;
            ctl10_reg     <= ctl9_reg;
            sel11_reg.fl  <= fl10_reg;
            sel11_reg.sz0 <= (s10_reg[0] == '0);
            sel11_reg.sz1 <= (s10_reg[1] == '0);
            ctl11_reg     <= ctl10_reg;
        end
    end

    // ------------------------------------------------------------------
    // Probability dividers
    // ------------------------------------------------------------------
    for (genvar j = 0; j < 2; j++)
    begin : g_prob
        llr_prob_div u_div (
            .clk (clk),
            .en  (en),
            .num (num11_reg[j]),
            .den (den11_reg[j]),
            .quo (pq_w[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            selp_reg[0] <= sel11_reg;
            ctlp_reg[0] <= ctl11_reg;
            for (int i = 1; i < PDL; i++)
            begin
                selp_reg[i] <= selp_reg[i-1];
                ctlp_reg[i] <= ctlp_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl_t ctl;
        sel_t sel;

        ctl             = ctlp_reg[PDL-1];
        sel             = selp_reg[PDL-1];
        res_w           = '0;
        res_w.gap_error = ctl.gap;
        if (!ctl.gap && (ctl.hm0 || ctl.hm1))
        begin
            res_w.updated              = 1'b1;
            res_w.best_combo           = sel.fl.flag;
            res_w.prob_hit0            = !ctl.hm0 ? PROB_ONE : (sel.sz0 ? PROB_HALF : pq_w[0]);
            res_w.prob_hit1            = !ctl.hm1 ? PROB_ONE : (sel.sz1 ? PROB_HALF : pq_w[1]);
            res_w.hit0_first_mirror    = sel.fl.f0;
            res_w.hit1_first_mirror    = sel.fl.f1;
            res_w.mirror0_first_mirror = ctl.hm0 && sel.fl.fm0;
            res_w.mirror1_first_mirror = ctl.hm1 && sel.fl.fm1;
        end
    end

    assign v_last    = vp_reg[PDL-1];
    assign take_out  = out_valid_reg && !out_stall;
    assign load_skid = !skid_valid_reg && v_last && out_valid_reg && !take_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            skid_valid_reg <= !take_out;
        end
        else
        begin
            if (!out_valid_reg || take_out)
            begin
                out_valid_reg <= v_last;
            end
            skid_valid_reg <= load_skid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || take_out)
        begin
            out_reg <= res_w;
        end
        if (load_skid)
        begin
            skid_reg <= res_w;
        end
    end

    assign out_valid            = out_valid_reg;
    assign updated              = out_reg.updated;
    assign gap_error            = out_reg.gap_error;
    assign best_combo           = out_reg.best_combo;
    assign prob_hit0            = out_reg.prob_hit0;
    assign prob_hit1            = out_reg.prob_hit1;
    assign hit0_first_mirror    = out_reg.hit0_first_mirror;
    assign hit1_first_mirror    = out_reg.hit1_first_mirror;
    assign mirror0_first_mirror = out_reg.mirror0_first_mirror;
    assign mirror1_first_mirror = out_reg.mirror1_first_mirror;

endmodule

[rtl/llr_checker.sv]
// ----------------------------------------------------------------------------
// llr_checker: port-level checks of the left/right ambiguity resolver
// Watches the result channel and the consistency of the result fields.
// ----------------------------------------------------------------------------
module llr_checker
    import llr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic signed [POS_W-1:0]  pos_hit0,
    input logic signed [POS_W-1:0]  plane_hit0,
    input logic signed [POS_W-1:0]  pos_hit1,
    input logic signed [POS_W-1:0]  plane_hit1,
    input logic                     has_mirror0,
    input logic signed [POS_W-1:0]  pos_mirror0,
    input logic                     has_mirror1,
    input logic signed [POS_W-1:0]  pos_mirror1,
    input logic signed [INC_W-1:0]  incidence,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     updated,
    input logic                     gap_error,
    input logic [1:0]               best_combo,
    input logic [PROB_W-1:0]        prob_hit0,
    input logic [PROB_W-1:0]        prob_hit1,
    input logic                     hit0_first_mirror,
    input logic                     hit1_first_mirror,
    input logic                     mirror0_first_mirror,
    input logic                     mirror1_first_mirror,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [FLOOR_W-1:0]       estimator_floor
);

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_BITS;

    // A result that waits for transfer stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(prob_hit0) && $stable(prob_hit1)
                                   && $stable(best_combo) && $stable(updated))
        else $error("stalled result changed");

    // A zero plane gap never yields an update.
    a_gap_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gap_error |-> !updated)
        else $error("update reported with zero plane gap");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !updated |-> prob_hit0 == '0 && prob_hit1 == '0 && best_combo == '0
                                  && !hit0_first_mirror && !hit1_first_mirror
                                  && !mirror0_first_mirror && !mirror1_first_mirror)
        else $error("fields set on a result without update");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && updated |-> prob_hit0 <= PROB_ONE && prob_hit1 <= PROB_ONE)
        else $error("probability above one");

endmodule

bind left_right_ambiguity_resolver llr_checker u_llr_checker (.*);
